[hdl/dafs_pkg.sv]
`default_nettype none

package dafs_pkg;

   localparam int COUNTER_BITS  = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 32;

   typedef enum logic [1:0] {
      ARM_INIT     = 2'd0,
      ARM_DISARMED = 2'd1,
      ARM_ARMED    = 2'd2,
      ARM_FAIL     = 2'd3
   } arm_state_type;

   typedef enum logic [1:0] {
      FL_GROUND   = 2'd0,
      FL_STARTING = 2'd1,
      FL_INFLIGHT = 2'd2,
      FL_LANDING  = 2'd3
   } flight_state_type;

   typedef enum logic [1:0] {
      CSR_BYPASS_RC    = 2'd0,
      CSR_START_THRUST = 2'd1,
      CSR_ABORT_THRUST = 2'd2,
      CSR_MIN_BATTERY  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        bypass_rc;
      logic [9:0]  start_thrust;
      logic [9:0]  abort_thrust;
      logic [15:0] min_battery_mv;
   } cfg_type;

   typedef struct packed {
      arm_state_type           arm;
      flight_state_type        flight;
      logic [COUNTER_BITS-1:0] start_count;
      logic                    arm_pending;
      logic                    stop_pending;
      logic                    usb_ctrl;
   } state_type;

   typedef struct packed {
      logic        offset_done;
      logic        rc_arm_switch;
      logic        rc_lost;
      logic        rc_auto;
      logic        mixer_ready;
      logic        battery_low;
      logic [9:0]  thrust;
      logic [15:0] climb_rate;
      logic [15:0] battery_mv;
      logic        arm_cmd;
      logic        stop_cmd;
   } item_type;

   typedef struct packed {
      arm_state_type    arm_now;
      flight_state_type flight_now;
      logic             usb_in_control;
      logic             arm_refused;
      logic             motors_stop;
      logic             band_update;
      logic [7:0]       band_red;
      logic [7:0]       band_green;
      logic [6:0]       band_blue;
   } result_type;

endpackage

`default_nettype wire

[hdl/dafs_csr.sv]
`default_nettype none

module dafs_csr
   import dafs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready,
   output cfg_type                       cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_BYPASS_RC:    cfg_in.bypass_rc      = csr_pwdata[0];
            CSR_START_THRUST: cfg_in.start_thrust   = csr_pwdata[9:0];
            CSR_ABORT_THRUST: cfg_in.abort_thrust   = csr_pwdata[9:0];
            CSR_MIN_BATTERY:  cfg_in.min_battery_mv = csr_pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_BYPASS_RC:    csr_prdata = CSR_DATA_BITS'(cfg_ff.bypass_rc);
         CSR_START_THRUST: csr_prdata = CSR_DATA_BITS'(cfg_ff.start_thrust);
         CSR_ABORT_THRUST: csr_prdata = CSR_DATA_BITS'(cfg_ff.abort_thrust);
         CSR_MIN_BATTERY:  csr_prdata = CSR_DATA_BITS'(cfg_ff.min_battery_mv);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bypass_rc      <= 1'b0;
         cfg_ff.start_thrust   <= 10'd200;
         cfg_ff.abort_thrust   <= 10'd300;
         cfg_ff.min_battery_mv <= 16'd10000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[hdl/dafs_core.sv]
`default_nettype none

module dafs_core
   import dafs_pkg::*;
(
   input  wire state_type  st,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output state_type       st_next,
   output result_type      result
);

   localparam logic signed [COUNTER_BITS-1:0] CNT_ZERO   = COUNTER_BITS'(0);
   localparam logic signed [COUNTER_BITS-1:0] CNT_ONE    = COUNTER_BITS'(1);
   localparam logic signed [COUNTER_BITS-1:0] CNT_TEN    = COUNTER_BITS'(10);
   localparam logic signed [COUNTER_BITS-1:0] CNT_DOWN   = COUNTER_BITS'(-1);
   localparam logic signed [COUNTER_BITS-1:0] CNT_LAUNCH = COUNTER_BITS'(200);
   localparam logic signed [COUNTER_BITS-1:0] CNT_REARM  = COUNTER_BITS'(1001);
   localparam logic signed [COUNTER_BITS-1:0] CNT_FLIGHT = COUNTER_BITS'(4000);
   localparam logic signed [15:0]             CLIMB_RISE = 16'sd150;
   localparam logic signed [15:0]             CLIMB_FAST = 16'sd700;

   function automatic logic signed [COUNTER_BITS-1:0] sat_add(
      input logic signed [COUNTER_BITS-1:0] v,
      input logic signed [COUNTER_BITS-1:0] d
   );
      logic signed [COUNTER_BITS:0] wide;
      wide = {v[COUNTER_BITS-1], v} + {d[COUNTER_BITS-1], d};
      if (wide[COUNTER_BITS] != wide[COUNTER_BITS-1]) begin
         sat_add = wide[COUNTER_BITS] ? {1'b1, {(COUNTER_BITS-1){1'b0}}}
                                      : {1'b0, {(COUNTER_BITS-1){1'b1}}};
      end else begin
         sat_add = wide[COUNTER_BITS-1:0];
      end
   endfunction

   logic                           pend_arm;
   logic                           pend_stop;
   logic                           arm_pend_nx;
   logic                           stop_pend_nx;
   logic                           arm_try;
   logic                           arm_ok;
   logic                           arm_fault;
   logic                           arm_quit;
   logic                           fail_clear;
   arm_state_type                  arm_nx;
   flight_state_type               flight_nx;
   logic signed [COUNTER_BITS-1:0] count;
   logic signed [COUNTER_BITS-1:0] count_nx;
   logic signed [COUNTER_BITS-1:0] count_start;
   logic signed [15:0]             climb;
   logic                           refused;
   logic                           mstop;
   logic                           band;

   assign pend_arm    = st.arm_pending | item.arm_cmd;
   assign pend_stop   = st.stop_pending | item.stop_cmd;
   assign arm_try     = pend_arm | item.rc_arm_switch;
   assign arm_ok      = item.mixer_ready & ~item.battery_low & (cfg.bypass_rc | ~item.rc_lost);
   assign arm_fault   = item.battery_low | (item.rc_lost & ~cfg.bypass_rc);
   assign arm_quit    = pend_stop | (~item.rc_arm_switch & ~cfg.bypass_rc);
   assign fail_clear  = ~item.rc_lost | cfg.bypass_rc | (st.flight == FL_GROUND);
   assign count       = $signed(st.start_count);
   assign climb       = $signed(item.climb_rate);
   assign count_start = (item.climb_rate != 16'd0 && climb > CLIMB_RISE
                         && item.battery_mv > cfg.min_battery_mv)
                        ? sat_add(count, CNT_TEN) : sat_add(count, CNT_DOWN);

   always_comb begin
      arm_nx       = st.arm;
      arm_pend_nx  = pend_arm;
      stop_pend_nx = pend_stop;
      unique case (st.arm)
         ARM_INIT: begin
            if (item.offset_done) arm_nx = ARM_DISARMED;
         end
         ARM_DISARMED: begin
            if (!item.offset_done) arm_nx = ARM_INIT;
            if (arm_try) begin
               if (arm_ok) arm_nx = ARM_ARMED;
               arm_pend_nx = 1'b0;
            end
         end
         ARM_ARMED: begin
            if (arm_fault) begin
               arm_nx = ARM_FAIL;
            end else if (arm_quit) begin
               arm_nx       = ARM_DISARMED;
               stop_pend_nx = 1'b0;
            end
         end
         ARM_FAIL: begin
            if (fail_clear) arm_nx = ARM_DISARMED;
         end
         default: arm_nx = st.arm;
      endcase
   end

   always_comb begin
      refused = 1'b0;
      mstop   = 1'b0;
      band    = 1'b0;
      unique case (st.arm)
         ARM_INIT:     ;
         ARM_DISARMED: refused = arm_try & ~arm_ok;
         ARM_ARMED: begin
            mstop = ~arm_fault & arm_quit;
            band  = ~arm_fault & ~arm_quit;
         end
         ARM_FAIL:     mstop = fail_clear;
         default:      ;
      endcase
   end

   always_comb begin
      flight_nx = st.flight;
      count_nx  = count;
      unique case (st.flight)
         FL_GROUND: begin
            if (item.thrust > cfg.start_thrust && arm_nx == ARM_ARMED) begin
               if (count > CNT_LAUNCH) begin
                  flight_nx = FL_STARTING;
                  count_nx  = CNT_REARM;
               end else begin
                  count_nx = sat_add(count, CNT_ONE);
               end
            end else begin
               count_nx = CNT_ZERO;
            end
         end
         FL_STARTING: begin
            if (item.thrust < cfg.abort_thrust) flight_nx = FL_GROUND;
            if (arm_nx == ARM_ARMED) begin
               count_nx = count_start;
               if (count_start <= CNT_ZERO) begin
                  flight_nx = FL_GROUND;
               end else if (count_start > CNT_FLIGHT || climb >= CLIMB_FAST) begin
                  flight_nx = FL_INFLIGHT;
               end
            end else begin
               flight_nx = FL_GROUND;
            end
         end
         FL_INFLIGHT: begin
            count_nx = sat_add(count, CNT_DOWN);
            if (arm_nx == ARM_DISARMED) flight_nx = FL_GROUND;
         end
         FL_LANDING: begin
            flight_nx = FL_GROUND;
            count_nx  = CNT_ZERO;
         end
         default: flight_nx = FL_GROUND;
      endcase
   end

   always_comb begin
      st_next.arm          = arm_nx;
      st_next.flight       = flight_nx;
      st_next.start_count  = count_nx;
      st_next.arm_pending  = arm_pend_nx;
      st_next.stop_pending = stop_pend_nx;
      if (cfg.bypass_rc) begin
         st_next.usb_ctrl = 1'b1;
      end else if (!item.rc_lost) begin
         st_next.usb_ctrl = item.rc_auto;
      end else begin
         st_next.usb_ctrl = st.usb_ctrl;
      end
   end

   always_comb begin
      result.arm_now        = arm_nx;
      result.flight_now     = flight_nx;
      result.usb_in_control = st_next.usb_ctrl;
      result.arm_refused    = refused;
      result.motors_stop    = mstop;
      result.band_update    = band;
      result.band_red       = band ? item.thrust[9:2] : 8'd0;
      result.band_green     = band ? ~item.thrust[9:2] : 8'd0;
      result.band_blue      = band ? item.thrust[9:3] : 7'd0;
   end

endmodule

`default_nettype wire

[hdl/drone_arm_flight_supervisor.sv]
// Arm and flight supervisor for a small multirotor, advanced once per sample tick. Each item on
// the request stream is one tick of sensor, radio and host status; each produces exactly one
// item on the response stream in the cycle after it is accepted, carrying both state
// machines, USB control, the refused-arm and motor-stop pulses and the armed LED band colour.
// One item can be accepted in every cycle: the whole update is a single pass of compare and
// saturating increment logic from the state registers into the response register, and
// req_tready falls only while a finished response is held by a low rsp_tready. Configuration
// registers must be written through the APB port while the stream is idle (not enforced).
`default_nettype none

module drone_arm_flight_supervisor
   import dafs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // req_tdata: offset_done, rc_arm_switch, rc_lost, rc_auto, mixer_ready, battery_low,
   // thrust[9:0], climb_rate[15:0], battery_mv[15:0], arm_cmd, stop_cmd, zero fill.
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // rsp_tdata: arm_now[1:0], flight_now[1:0], usb_in_control, arm_refused, motors_stop,
   // band_update, band_red[7:0], band_green[7:0], band_blue[6:0], zero fill.
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   cfg_type    cfg;
   item_type   item;
   state_type  state_ff;
   state_type  state_in;
   result_type result;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   dafs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign item.offset_done   = req_tdata[0];
   assign item.rc_arm_switch = req_tdata[1];
   assign item.rc_lost       = req_tdata[2];
   assign item.rc_auto       = req_tdata[3];
   assign item.mixer_ready   = req_tdata[4];
   assign item.battery_low   = req_tdata[5];
   assign item.thrust        = req_tdata[15:6];
   assign item.climb_rate    = req_tdata[31:16];
   assign item.battery_mv    = req_tdata[47:32];
   assign item.arm_cmd       = req_tdata[48];
   assign item.stop_cmd      = req_tdata[49];

   dafs_core u_core (
      .st      (state_ff),
      .item    (item),
      .cfg     (cfg),
      .st_next (state_in),
      .result  (result)
   );

   assign req_tready   = ~rsp_valid_ff | rsp_tready;
   assign accept       = req_tvalid & req_tready;
   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_tready);
   assign rsp_in       = accept ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.arm          <= ARM_INIT;
         state_ff.flight       <= FL_GROUND;
         state_ff.start_count  <= '0;
         state_ff.arm_pending  <= 1'b0;
         state_ff.stop_pending <= 1'b0;
         state_ff.usb_ctrl     <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         if (accept) state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.band_blue, rsp_ff.band_green, rsp_ff.band_red,
                        rsp_ff.band_update, rsp_ff.motors_stop, rsp_ff.arm_refused,
                        rsp_ff.usb_in_control, rsp_ff.flight_now, rsp_ff.arm_now};

   a_stop_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.motors_stop) |-> (rsp_ff.arm_now == ARM_DISARMED))
      else $error("motor stop reported without a disarmed state");

   a_band_armed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.band_update) |-> (rsp_ff.arm_now == ARM_ARMED))
      else $error("band colour reported while not armed");

   a_refused_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.arm_refused)
      |-> (rsp_ff.arm_now == ARM_INIT || rsp_ff.arm_now == ARM_DISARMED))
      else $error("refused arm left the machine armed or failed");

   a_starting_armed: assert property (@(posedge clock) disable iff (reset)
      (state_ff.flight == FL_STARTING) |-> (state_ff.arm == ARM_ARMED))
      else $error("starting state held while not armed");

   a_no_landing: assert property (@(posedge clock) disable iff (reset)
      state_ff.flight != FL_LANDING)
      else $error("landing state entered");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("state changed without an accepted item");

endmodule

`default_nettype wire
